>>> src/dnip_pkg.sv
// Package for the deref name/index parser: shared constants and the
// result record passed from the parse core to the top level.
// No dependencies.
package dnip_pkg;

   localparam int NAME_MAX_LEN_DEF = 255;

   localparam int CH_W     = 8;
   localparam int INDEX_W  = 31;
   localparam int STATUS_W = 3;

   localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

   localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
   localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [CH_W-1:0] CH_LBRACK = 8'h5B;
   localparam logic [CH_W-1:0] CH_RBRACK = 8'h5D;
   localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
   localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
   localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;

   localparam logic [3:0] DEC_RADIX = 4'd10;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BRACKET  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TRAILING = 3'd2;
   localparam logic [STATUS_W-1:0] ST_LONGNAME = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

   localparam int RSP_DATA_W = 48;

   typedef struct packed {
      logic                has_result;
      logic                is_final;
      logic [CH_W-1:0]     name_char;
      logic                deref_flag;
      logic [INDEX_W-1:0]  index_value;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

>>> src/deref_name_index_parser.sv
// Top level of the deref name/index parser: input register, parse core
// and result register with the stream handshakes.
// Depends on dnip_pkg and dnip_core.
//
//   channel | direction | tdata fields (low bit up)                   | tlast
//   req     | in        | ch[7:0]                                     | -
//   rsp     | out       | name_char, deref_flag, index_value, status  | is_final
//
// One character per cycle unless a stalled result holds the input: a
// character is parsed while it sits in the input register and its result
// (if any) loads into the result register when the character advances.
// Unstalled rate is one character per clock, set by the single parse stage.
// Reset (synchronous) returns the parser to the leading whitespace phase and
// empties both registers. A stalled result holds only characters that would
// produce a result; characters that produce none still drain.
module deref_name_index_parser #(
   parameter int NAME_MAX_LEN = dnip_pkg::NAME_MAX_LEN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] ch
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] name_char, [8] deref_flag, [39:9] index_value, [42:40] status, zero fill
   output logic [dnip_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast    // is_final
);

   localparam int USED_W = dnip_pkg::CH_W + 1 + dnip_pkg::INDEX_W + dnip_pkg::STATUS_W;

   logic                          in_valid_ff, in_valid_in;
   logic [dnip_pkg::CH_W-1:0]     in_ch_ff;
   logic                          out_valid_ff, out_valid_in;
   logic [dnip_pkg::RSP_DATA_W-1:0] out_data_ff;
   logic                          out_last_ff;
   logic                          advance;
   logic                          out_load;
   dnip_pkg::result_type          result;

   dnip_core #(
      .NAME_MAX_LEN(NAME_MAX_LEN)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .ch     (in_ch_ff),
      .result (result)
   );

   assign advance    = in_valid_ff &&
                       (!out_valid_ff || rsp_tready || !result.has_result);
   assign out_load   = advance && result.has_result;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = req_tvalid ? 1'b1 : (in_valid_ff && !advance);
      out_valid_in = out_load ? 1'b1 : (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload: capture on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ch_ff <= req_tdata;
      end
      if (out_load) begin
         out_data_ff <= {{(dnip_pkg::RSP_DATA_W - USED_W){1'b0}},
                         result.status, result.index_value,
                         result.deref_flag, result.name_char};
         out_last_ff <= result.is_final;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

>>> src/dnip_core.sv
// Parse core: phase register, star flag, index accumulator, name length
// and first-error register, with the per-character next-state logic.
// Depends on dnip_pkg.
module dnip_core #(
   parameter int NAME_MAX_LEN = dnip_pkg::NAME_MAX_LEN_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [dnip_pkg::CH_W-1:0]  ch,
   output dnip_pkg::result_type       result
);

   localparam int NL_W = $clog2(NAME_MAX_LEN + 1);
   localparam logic [NL_W-1:0] NL_LIMIT = NL_W'(NAME_MAX_LEN);

   localparam logic [3:0] PH_LEAD     = 4'd0;
   localparam logic [3:0] PH_PRENAME  = 4'd1;
   localparam logic [3:0] PH_NAME     = 4'd2;
   localparam logic [3:0] PH_POSTNAME = 4'd3;
   localparam logic [3:0] PH_IDXPRE   = 4'd4;
   localparam logic [3:0] PH_DIGITS   = 4'd5;
   localparam logic [3:0] PH_IDXPOST  = 4'd6;
   localparam logic [3:0] PH_DONE     = 4'd7;
   localparam logic [3:0] PH_SKIP     = 4'd8;

   localparam int PROD_W = dnip_pkg::INDEX_W + 4;

   logic [3:0]                      phase_ff, phase_in;
   logic                            star_ff, star_in;
   logic [dnip_pkg::INDEX_W-1:0]    index_ff, index_in;
   logic [NL_W-1:0]                 name_len_ff, name_len_in;
   logic [dnip_pkg::STATUS_W-1:0]   err_ff, err_in;

   logic                            is_ws;
   logic                            is_digit;
   logic                            do_name;
   logic [PROD_W-1:0]               prod;
   logic [dnip_pkg::INDEX_W-1:0]    digit_index;
   logic                            digit_ovf;

   assign is_ws    = ((ch >= dnip_pkg::CH_TAB) && (ch <= dnip_pkg::CH_CR)) ||
                     (ch == dnip_pkg::CH_SPACE);
   assign is_digit = (ch >= dnip_pkg::CH_ZERO) && (ch <= dnip_pkg::CH_NINE);

   // acc * 10 + digit as shifts and adds
   always_comb begin
      prod = (PROD_W'(index_ff) << 3) + (PROD_W'(index_ff) << 1) +
             PROD_W'(ch - dnip_pkg::CH_ZERO);
      digit_ovf   = (prod > PROD_W'(dnip_pkg::INDEX_MAX));
      digit_index = digit_ovf ? dnip_pkg::INDEX_MAX : prod[dnip_pkg::INDEX_W-1:0];
   end

   always_comb begin
      phase_in    = phase_ff;
      star_in     = star_ff;
      index_in    = index_ff;
      name_len_in = name_len_ff;
      err_in      = err_ff;
      do_name     = 1'b0;
      result      = '0;

      if (ch == dnip_pkg::CH_NUL) begin
         if ((phase_ff == PH_IDXPRE || phase_ff == PH_DIGITS ||
              phase_ff == PH_IDXPOST) && err_ff == dnip_pkg::ST_OK) begin
            err_in = dnip_pkg::ST_BRACKET;
         end
         result.has_result  = 1'b1;
         result.is_final    = 1'b1;
         result.deref_flag  = star_ff;
         result.index_value = index_ff;
         result.status      = err_in;
         // clear for the next string
         phase_in    = PH_LEAD;
         star_in     = 1'b0;
         index_in    = '0;
         name_len_in = '0;
         err_in      = dnip_pkg::ST_OK;
      end else begin
         case (phase_ff)
            PH_LEAD: begin
               if (ch == dnip_pkg::CH_STAR) begin
                  star_in  = 1'b1;
                  phase_in = PH_PRENAME;
               end else if (!is_ws) begin
                  do_name = 1'b1;
               end
            end
            PH_PRENAME: begin
               if (!is_ws) begin
                  do_name = 1'b1;
               end
            end
            PH_NAME: begin
               do_name = 1'b1;
            end
            PH_POSTNAME: begin
               if (ch == dnip_pkg::CH_LBRACK) begin
                  phase_in = PH_IDXPRE;
               end else if (!is_ws) begin
                  if (err_ff == dnip_pkg::ST_OK) err_in = dnip_pkg::ST_TRAILING;
                  phase_in = PH_SKIP;
               end
            end
            PH_IDXPRE, PH_DIGITS, PH_IDXPOST: begin
               if (is_ws) begin
                  if (phase_ff == PH_DIGITS) phase_in = PH_IDXPOST;
               end else if (is_digit && phase_ff != PH_IDXPOST) begin
                  index_in = digit_index;
                  if (digit_ovf && err_ff == dnip_pkg::ST_OK) begin
                     err_in = dnip_pkg::ST_OVERFLOW;
                  end
                  phase_in = PH_DIGITS;
               end else if (ch == dnip_pkg::CH_RBRACK) begin
                  phase_in = PH_DONE;
               end else begin
                  if (err_ff == dnip_pkg::ST_OK) err_in = dnip_pkg::ST_BRACKET;
                  phase_in = PH_SKIP;
               end
            end
            PH_DONE: begin
               if (!is_ws) begin
                  if (err_ff == dnip_pkg::ST_OK) err_in = dnip_pkg::ST_TRAILING;
                  phase_in = PH_SKIP;
               end
            end
            default: begin
               phase_in = PH_SKIP;
            end
         endcase

         if (do_name) begin
            if (is_ws) begin
               phase_in = PH_POSTNAME;
            end else if (ch == dnip_pkg::CH_LBRACK) begin
               phase_in = PH_IDXPRE;
            end else if (name_len_ff >= NL_LIMIT) begin
               // drop the character, keep parsing
               if (err_ff == dnip_pkg::ST_OK) err_in = dnip_pkg::ST_LONGNAME;
               phase_in = PH_NAME;
            end else begin
               name_len_in       = name_len_ff + 1'b1;
               phase_in          = PH_NAME;
               result.has_result = 1'b1;
               result.name_char  = ch;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LEAD;
         star_ff     <= 1'b0;
         index_ff    <= '0;
         name_len_ff <= '0;
         err_ff      <= dnip_pkg::ST_OK;
      end else if (step) begin
         phase_ff    <= phase_in;
         star_ff     <= star_in;
         index_ff    <= index_in;
         name_len_ff <= name_len_in;
         err_ff      <= err_in;
      end
   end

endmodule
